>>> hw/rtl/connection_table_lookup_unit_assert.svh
// ----------------------------------------------------------------------------
// connection table lookup: assertion macros
// shorthand for clocked implication checks with reset disable
// ----------------------------------------------------------------------------
`ifndef CONNECTION_TABLE_LOOKUP_UNIT_ASSERT_SVH
`define CONNECTION_TABLE_LOOKUP_UNIT_ASSERT_SVH

// same-cycle implication
`define CTL_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("connection table check failed");

// next-cycle implication
`define CTL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("connection table check failed");

`endif

>>> hw/rtl/ctl_pkg.sv
// ----------------------------------------------------------------------------
// ctl_pkg
// shared constants, codes and types of the connection table lookup unit
// ----------------------------------------------------------------------------
package ctl_pkg;

	// table geometry, line count is a power of two
	localparam int TABLE_LINES = 256;
	localparam int TABLE_WAYS  = 4;
	localparam int LINE_W      = $clog2(TABLE_LINES);
	localparam int WAY_W       = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
	localparam int SLOT_COUNT  = TABLE_LINES * TABLE_WAYS;
	localparam int SLOT_W      = $clog2(SLOT_COUNT);

	// field widths
	localparam int TUPLE_W    = 64;
	localparam int HASH_W     = 32;
	localparam int CMD_W      = 2;
	localparam int STATUS_W   = 2;
	localparam int LINE_OUT_W = 8;
	localparam int WAY_OUT_W  = 2;

	// fnv-1 constants
	localparam logic [HASH_W-1:0] FNV_BASIS  = 32'h811c9dc5;
	localparam logic [HASH_W-1:0] FNV_PRIME  = 32'h01000193;
	localparam int                FNV_ROUNDS = TUPLE_W / 8;

	// command codes
	localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_HIT  = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

	// hash unit response
	typedef struct packed {
		logic              done;
		logic [HASH_W-1:0] hash;
	} ctl_fnv_rsp_t;

endpackage

>>> hw/rtl/ctl_fnv_unit.sv
// ----------------------------------------------------------------------------
// ctl_fnv_unit
// iterative fnv-1 hash of a 64-bit tuple, one byte per cycle, msb first
// ----------------------------------------------------------------------------
module ctl_fnv_unit import ctl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [TUPLE_W-1:0] key,
	output ctl_fnv_rsp_t       rsp
);

	localparam int CNT_W = $clog2(FNV_ROUNDS);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [HASH_W-1:0]  hash_q;
	logic [TUPLE_W-1:0] shift_q;
	logic [HASH_W-1:0]  product;

	// shared multiplier, low half only
	assign product = hash_q * FNV_PRIME;

	// round sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(FNV_ROUNDS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// hash state and byte shifter
	always_ff @(posedge clk) begin
		if (start) begin
			hash_q  <= FNV_BASIS;
			shift_q <= key;
		end else if (busy_q) begin
			hash_q  <= product ^ {{(HASH_W-8){1'b0}}, shift_q[TUPLE_W-1 -: 8]};
			shift_q <= shift_q << 8;
		end
	end

	assign rsp.done = done_q;
	assign rsp.hash = hash_q;

endmodule

>>> hw/rtl/connection_table_lookup_unit.sv
// ----------------------------------------------------------------------------
// connection_table_lookup_unit
// set-associative connection table with fnv-1 line hashing
// ----------------------------------------------------------------------------
// Commands come in on the s_axis word (tuser = command, tdata = tuple) and
// each one gives exactly one m_axis word (tuser = status, tdata = line and
// way). Lookup reports the first valid matching way, allocate claims the
// first free way, release clears the valid bit of the first match.
// An accepted word is hashed on one shared 32x32 multiplier, the valid
// row and the tuples of the line are read from block memories and the
// ways are compared one per cycle on a single 64-bit comparator. Each
// word goes through the hash, read and scan states, a write-back state
// for a successful allocate or release, and the output register load.
// The next word can be taken in the cycle after the result is loaded;
// none is taken while one is in progress. After reset the valid memory
// is swept, one line per cycle, over all 256 lines; s_axis_tready stays
// low meanwhile. If m_axis_tready is low, the result sits in the output
// register; the unit then holds the following result until the register
// frees up and takes no new word until that happens.
// ----------------------------------------------------------------------------
module connection_table_lookup_unit import ctl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // remote_ip[31:0], local_port[47:32], remote_port[63:48]
	input  logic [1:0]  s_axis_tuser,  // command[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // line_index[7:0], way_index[9:8], zero[15:10]
	output logic [1:0]  m_axis_tuser   // status[1:0]
);

	// sequencer states
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_HASH  = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_SCAN  = 3'd4;
	localparam logic [2:0] ST_WRITE = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	logic [2:0]            state_q;
	logic [LINE_W-1:0]     clr_q;
	logic [CMD_W-1:0]      cmd_q;
	logic [TUPLE_W-1:0]    key_q;
	logic [LINE_W-1:0]     line_q;
	logic [WAY_W-1:0]      way_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic [WAY_W-1:0]      res_way_q;
	logic                  m_tvalid_q;
	logic [STATUS_W-1:0]   m_status_q;
	logic [LINE_OUT_W-1:0] m_line_q;
	logic [WAY_OUT_W-1:0]  m_way_q;

	logic [TABLE_WAYS-1:0] valid_mem [TABLE_LINES];
	logic [TUPLE_W-1:0]    tuple_mem [SLOT_COUNT];
	logic [TABLE_WAYS-1:0] valid_rd_q;
	logic [TUPLE_W-1:0]    tuple_rd_q;

	logic                  accept;
	logic [TUPLE_W-1:0]    in_tuple;
	ctl_fnv_rsp_t          fnv_rsp;
	logic                  way_last;
	logic                  is_search;
	logic                  way_hit;
	logic                  way_free;
	logic                  found;
	logic                  out_free;
	logic                  tuple_rd_en;
	logic [SLOT_W-1:0]     tuple_rd_addr;
	logic [SLOT_W-1:0]     cur_slot;
	logic [TABLE_WAYS-1:0] valid_wr_row;

	function automatic logic [SLOT_W-1:0] slot_of(logic [LINE_W-1:0] line,
			logic [WAY_W-1:0] way);
		return SLOT_W'(int'(line) * TABLE_WAYS + int'(way));
	endfunction

	// input handshake and tuple packing
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign in_tuple      = {s_axis_tdata[31:0], s_axis_tdata[47:32], s_axis_tdata[63:48]};

	ctl_fnv_unit u_fnv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.key    (in_tuple),
		.rsp    (fnv_rsp)
	);

	// way compare on the shared comparator
	assign way_last  = (way_q == WAY_W'(TABLE_WAYS - 1));
	assign is_search = (cmd_q == CMD_LOOKUP) || (cmd_q == CMD_RELEASE);
	assign way_hit   = valid_rd_q[way_q] && (tuple_rd_q == key_q);
	assign way_free  = !valid_rd_q[way_q];
	assign found     = (cmd_q == CMD_ALLOC) ? way_free : (is_search && way_hit);
	assign out_free  = !m_tvalid_q || m_axis_tready;
	assign cur_slot  = slot_of(line_q, way_q);

	// tuple read address: way 0 on entry, next way while scanning
	always_comb begin
		tuple_rd_en   = 1'b0;
		tuple_rd_addr = slot_of(line_q, '0);
		case (state_q)
			ST_READ: begin
				tuple_rd_en = 1'b1;
			end
			ST_SCAN: begin
				tuple_rd_en   = !way_last;
				tuple_rd_addr = slot_of(line_q, way_q + WAY_W'(1));
			end
			default: begin
				tuple_rd_en = 1'b0;
			end
		endcase
	end

	// updated valid row for allocate or release
	always_comb begin
		valid_wr_row         = valid_rd_q;
		valid_wr_row[way_q]  = (cmd_q == CMD_ALLOC);
	end

	// valid memory, one row per line
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			valid_mem[clr_q] <= '0;
		end else if (state_q == ST_WRITE) begin
			valid_mem[line_q] <= valid_wr_row;
		end
		if (state_q == ST_READ) begin
			valid_rd_q <= valid_mem[line_q];
		end
	end

	// tuple memory, one entry per slot
	always_ff @(posedge clk) begin
		if (state_q == ST_WRITE && cmd_q == CMD_ALLOC) begin
			tuple_mem[cur_slot] <= key_q;
		end
		if (tuple_rd_en) begin
			tuple_rd_q <= tuple_mem[tuple_rd_addr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_axis_tready && !(state_q == ST_FIN && out_free)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + LINE_W'(1);
					if (clr_q == LINE_W'(TABLE_LINES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					if (fnv_rsp.done) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (found) begin
						state_q <= (cmd_q == CMD_LOOKUP) ? ST_FIN : ST_WRITE;
					end else if (way_last) begin
						state_q <= ST_FIN;
					end
				end
				ST_WRITE: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item payload and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= s_axis_tuser;
			key_q <= in_tuple;
		end
		if (state_q == ST_HASH && fnv_rsp.done) begin
			line_q <= fnv_rsp.hash[LINE_W-1:0];
		end
		if (state_q == ST_READ) begin
			way_q        <= '0;
			res_status_q <= STAT_MISS;
			res_way_q    <= '0;
		end else if (state_q == ST_SCAN) begin
			if (found) begin
				res_status_q <= STAT_HIT;
				res_way_q    <= way_q;
			end else if (way_last) begin
				res_status_q <= (cmd_q == CMD_ALLOC) ? STAT_FULL : STAT_MISS;
			end else begin
				way_q <= way_q + WAY_W'(1);
			end
		end
		if (state_q == ST_FIN && out_free) begin
			m_status_q <= res_status_q;
			m_line_q   <= LINE_OUT_W'(line_q);
			m_way_q    <= WAY_OUT_W'(res_way_q);
		end
	end

	// output word
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tdata  = {{(16 - LINE_OUT_W - WAY_OUT_W){1'b0}}, m_way_q, m_line_q};

	// checks
	`include "connection_table_lookup_unit_assert.svh"

	`CTL_ASSERT_IMP(a_no_accept_clearing, state_q == ST_CLEAR, !s_axis_tready)
	`CTL_ASSERT_IMP(a_hash_done_in_hash, fnv_rsp.done, state_q == ST_HASH)
	`CTL_ASSERT_NEXT(a_fin_loads_output, state_q == ST_FIN && out_free, m_axis_tvalid)
	`CTL_ASSERT_IMP(a_way_zero_on_fail, m_tvalid_q && m_status_q != STAT_HIT, m_way_q == '0)

endmodule
